// File: src/caldc_pkg.sv
// Types, constants and calendar functions shared by the date counter files.
package caldc_pkg;

   localparam int unsigned DAY_W   = 5;
   localparam int unsigned MONTH_W = 4;
   localparam int unsigned YEAR_W  = 14;
   localparam int unsigned COUNT_W = 16;

   localparam logic [DAY_W-1:0]   RESET_DAY   = DAY_W'(1);
   localparam logic [MONTH_W-1:0] RESET_MONTH = MONTH_W'(1);
   localparam logic [YEAR_W-1:0]  RESET_YEAR  = YEAR_W'(2000);
   localparam logic               RESET_LEAP  = 1'b1;

   localparam logic [MONTH_W-1:0] JANUARY  = MONTH_W'(1);
   localparam logic [MONTH_W-1:0] FEBRUARY = MONTH_W'(2);
   localparam logic [MONTH_W-1:0] DECEMBER = MONTH_W'(12);
   localparam logic [DAY_W-1:0]   LAST_DAY_OF_YEAR = DAY_W'(31);

   // floor(y / 25) = (y * RECIP_25) >> RECIP_SHIFT, exact for every 14-bit year
   localparam int unsigned          RECIP_SHIFT = 20;
   localparam int unsigned          RECIP_W     = 16;
   localparam logic [RECIP_W-1:0]   RECIP_25    = RECIP_W'(41944);
   localparam int unsigned          PROD_W      = YEAR_W + RECIP_W;

   typedef enum logic [1:0] {
      OP_NEXT = 2'd0,
      OP_PREV = 2'd1,
      OP_ADD  = 2'd2,
      OP_LOAD = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_STEP,
      ST_LEAP,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic load;
      logic step;
      logic leap;
      logic emit;
   } cmd_type;

   typedef struct packed {
      op_type op;
      logic   invalid;
      logic   cnt_zero;
      logic   step_err;
      logic   year_wrap;
      logic   rsp_free;
   } stat_type;

   function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] month,
                                                  input logic               leap);
      logic [DAY_W-1:0] len;
      case (month)
         4'd2:                                    len = leap ? DAY_W'(29) : DAY_W'(28);
         4'd4, 4'd6, 4'd9, 4'd11:                 len = DAY_W'(30);
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = DAY_W'(31);
         default:                                 len = DAY_W'(0);
      endcase
      return len;
   endfunction

   function automatic logic leap_of(input logic [YEAR_W-1:0] year);
      logic [PROD_W-1:0] prod;
      logic [YEAR_W-1:0] quot;
      logic [YEAR_W-1:0] rem;
      logic              div25;
      prod  = PROD_W'(year) * PROD_W'(RECIP_25);
      quot  = YEAR_W'(prod >> RECIP_SHIFT);
      rem   = year - YEAR_W'((quot << 4) + (quot << 3) + quot);
      div25 = (rem == '0);
      return (year[1:0] == 2'b00) && (!div25 || (year[3:0] == 4'b0000));
   endfunction

endpackage

// File: src/caldc_req_if.sv
// Request and response channel interfaces of the date counter.
interface caldc_req_if;
   logic                                valid;
   logic                                ready;
   caldc_pkg::op_type                   op;
   logic [caldc_pkg::COUNT_W-1:0]       day_count;
   logic [caldc_pkg::DAY_W-1:0]         load_day;
   logic [caldc_pkg::MONTH_W-1:0]       load_month;
   logic [caldc_pkg::YEAR_W-1:0]        load_year;

   modport source (output valid, op, day_count, load_day, load_month, load_year,
                   input ready);
   modport sink   (input valid, op, day_count, load_day, load_month, load_year,
                   output ready);
endinterface

interface caldc_rsp_if;
   logic                                valid;
   logic                                ready;
   logic [caldc_pkg::DAY_W-1:0]         out_day;
   logic [caldc_pkg::MONTH_W-1:0]       out_month;
   logic [caldc_pkg::YEAR_W-1:0]        out_year;
   logic                                date_invalid;
   logic                                range_error;

   modport source (output valid, out_day, out_month, out_year, date_invalid, range_error,
                   input ready);
   modport sink   (input valid, out_day, out_month, out_year, date_invalid, range_error,
                   output ready);
endinterface

// File: src/caldc_dpath.sv
// Datapath of the date counter: date state, step logic, leap update and response register.
module caldc_dpath #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic                              clock,
   input  logic                              reset,
   input  caldc_pkg::cmd_type                cmd,
   output caldc_pkg::stat_type               stat,
   input  caldc_pkg::op_type                 req_op,
   input  logic [caldc_pkg::COUNT_W-1:0]     req_day_count,
   input  logic [caldc_pkg::DAY_W-1:0]       req_load_day,
   input  logic [caldc_pkg::MONTH_W-1:0]     req_load_month,
   input  logic [caldc_pkg::YEAR_W-1:0]      req_load_year,
   input  logic                              rsp_ready,
   output logic                              rsp_valid,
   output logic [caldc_pkg::DAY_W-1:0]       rsp_out_day,
   output logic [caldc_pkg::MONTH_W-1:0]     rsp_out_month,
   output logic [caldc_pkg::YEAR_W-1:0]      rsp_out_year,
   output logic                              rsp_date_invalid,
   output logic                              rsp_range_error
);

   localparam logic [caldc_pkg::YEAR_W-1:0] MaxYear = caldc_pkg::YEAR_W'(MAX_YEAR);
   localparam logic [caldc_pkg::YEAR_W-1:0] MinYear = caldc_pkg::YEAR_W'(1);

   caldc_pkg::op_type                 op_ff, op_in;
   logic [caldc_pkg::COUNT_W-1:0]     cnt_ff, cnt_in;
   logic [caldc_pkg::DAY_W-1:0]       day_ff, day_in;
   logic [caldc_pkg::MONTH_W-1:0]     month_ff, month_in;
   logic [caldc_pkg::YEAR_W-1:0]      year_ff, year_in;
   logic                              leap_ff, leap_in;
   logic                              rerr_ff, rerr_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic [caldc_pkg::DAY_W-1:0]       out_day_ff, out_day_in;
   logic [caldc_pkg::MONTH_W-1:0]     out_month_ff, out_month_in;
   logic [caldc_pkg::YEAR_W-1:0]      out_year_ff, out_year_in;
   logic                              out_inv_ff, out_inv_in;
   logic                              out_rerr_ff, out_rerr_in;

   logic [caldc_pkg::DAY_W-1:0]       mlen;
   logic [caldc_pkg::DAY_W-1:0]       prev_mlen;
   logic [caldc_pkg::MONTH_W-1:0]     prev_month;
   logic                              invalid;
   logic                              step_back;
   logic                              fwd_roll, fwd_wrap, fwd_err;
   logic                              back_roll, back_wrap, back_err;
   logic                              step_err;

   assign mlen       = caldc_pkg::month_len(month_ff, leap_ff);
   assign prev_month = month_ff - caldc_pkg::MONTH_W'(1);
   assign prev_mlen  = caldc_pkg::month_len(prev_month, leap_ff);
   assign invalid    = (month_ff < caldc_pkg::JANUARY) || (month_ff > caldc_pkg::DECEMBER) ||
                       (day_ff == '0) || (day_ff > mlen);

   assign step_back  = (op_ff == caldc_pkg::OP_PREV);
   assign fwd_roll   = (day_ff >= mlen);
   assign fwd_wrap   = fwd_roll && (month_ff >= caldc_pkg::DECEMBER);
   assign fwd_err    = fwd_wrap && (year_ff >= MaxYear);
   assign back_roll  = (day_ff <= caldc_pkg::DAY_W'(1));
   assign back_wrap  = back_roll && (month_ff <= caldc_pkg::JANUARY);
   assign back_err   = back_wrap && (year_ff <= MinYear);
   assign step_err   = step_back ? back_err : fwd_err;

   always_comb begin
      stat.op        = op_ff;
      stat.invalid   = invalid;
      stat.cnt_zero  = (cnt_ff == '0);
      stat.step_err  = step_err;
      stat.year_wrap = step_back ? back_wrap : fwd_wrap;
      stat.rsp_free  = !rsp_valid_ff || rsp_ready;
   end

   always_comb begin
      op_in    = op_ff;
      cnt_in   = cnt_ff;
      day_in   = day_ff;
      month_in = month_ff;
      year_in  = year_ff;
      leap_in  = leap_ff;
      rerr_in  = rerr_ff;
      if (cmd.load) begin
         op_in   = req_op;
         cnt_in  = req_day_count;
         rerr_in = 1'b0;
         if (req_op == caldc_pkg::OP_LOAD) begin
            day_in   = req_load_day;
            month_in = req_load_month;
            if (req_load_year < MinYear) begin
               year_in = MinYear;
               rerr_in = 1'b1;
            end else if (req_load_year > MaxYear) begin
               year_in = MaxYear;
               rerr_in = 1'b1;
            end else begin
               year_in = req_load_year;
            end
         end
      end else if (cmd.step) begin
         if (op_ff == caldc_pkg::OP_ADD) begin
            cnt_in = cnt_ff - caldc_pkg::COUNT_W'(1);
         end
         if (step_err) begin
            rerr_in = 1'b1;
         end else if (step_back) begin
            if (back_wrap) begin
               year_in  = year_ff - caldc_pkg::YEAR_W'(1);
               month_in = caldc_pkg::DECEMBER;
               day_in   = caldc_pkg::LAST_DAY_OF_YEAR;
            end else if (back_roll) begin
               month_in = prev_month;
               day_in   = prev_mlen;
            end else begin
               day_in = day_ff - caldc_pkg::DAY_W'(1);
            end
         end else begin
            if (fwd_wrap) begin
               year_in  = year_ff + caldc_pkg::YEAR_W'(1);
               month_in = caldc_pkg::JANUARY;
               day_in   = caldc_pkg::DAY_W'(1);
            end else if (fwd_roll) begin
               month_in = month_ff + caldc_pkg::MONTH_W'(1);
               day_in   = caldc_pkg::DAY_W'(1);
            end else begin
               day_in = day_ff + caldc_pkg::DAY_W'(1);
            end
         end
      end else if (cmd.leap) begin
         leap_in = caldc_pkg::leap_of(year_ff);
      end
   end

   always_comb begin
      out_day_in   = out_day_ff;
      out_month_in = out_month_ff;
      out_year_in  = out_year_ff;
      out_inv_in   = out_inv_ff;
      out_rerr_in  = out_rerr_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      if (cmd.emit) begin
         out_day_in   = day_ff;
         out_month_in = month_ff;
         out_year_in  = year_ff;
         out_inv_in   = invalid;
         out_rerr_in  = rerr_ff;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      cnt_ff       <= cnt_in;
      rerr_ff      <= rerr_in;
      out_day_ff   <= out_day_in;
      out_month_ff <= out_month_in;
      out_year_ff  <= out_year_in;
      out_inv_ff   <= out_inv_in;
      out_rerr_ff  <= out_rerr_in;
      if (reset) begin
         day_ff       <= caldc_pkg::RESET_DAY;
         month_ff     <= caldc_pkg::RESET_MONTH;
         year_ff      <= caldc_pkg::RESET_YEAR;
         leap_ff      <= caldc_pkg::RESET_LEAP;
         rsp_valid_ff <= 1'b0;
      end else begin
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         leap_ff      <= leap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_out_day      = out_day_ff;
   assign rsp_out_month    = out_month_ff;
   assign rsp_out_year     = out_year_ff;
   assign rsp_date_invalid = out_inv_ff;
   assign rsp_range_error  = out_rerr_ff;

endmodule

// File: src/caldc_ctrl.sv
// Controller state machine of the date counter.
module caldc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  caldc_pkg::stat_type  stat,
   output caldc_pkg::cmd_type   cmd
);

   caldc_pkg::state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         caldc_pkg::ST_IDLE: begin
            if (req_valid) begin
               state_in = caldc_pkg::ST_STEP;
            end
         end
         caldc_pkg::ST_STEP: begin
            if (stat.op == caldc_pkg::OP_LOAD) begin
               state_in = caldc_pkg::ST_LEAP;
            end else if (stat.invalid || stat.step_err) begin
               state_in = caldc_pkg::ST_DONE;
            end else if (stat.op == caldc_pkg::OP_ADD && stat.cnt_zero) begin
               state_in = caldc_pkg::ST_DONE;
            end else if (stat.year_wrap) begin
               state_in = caldc_pkg::ST_LEAP;
            end else if (stat.op != caldc_pkg::OP_ADD) begin
               state_in = caldc_pkg::ST_DONE;
            end
         end
         caldc_pkg::ST_LEAP: begin
            state_in = (stat.op == caldc_pkg::OP_ADD) ? caldc_pkg::ST_STEP
                                                      : caldc_pkg::ST_DONE;
         end
         caldc_pkg::ST_DONE: begin
            if (stat.rsp_free) begin
               state_in = caldc_pkg::ST_IDLE;
            end
         end
         default: state_in = caldc_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         caldc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         caldc_pkg::ST_STEP: begin
            cmd.step = (stat.op != caldc_pkg::OP_LOAD) && !stat.invalid &&
                       !(stat.op == caldc_pkg::OP_ADD && stat.cnt_zero);
         end
         caldc_pkg::ST_LEAP: begin
            cmd.leap = 1'b1;
         end
         caldc_pkg::ST_DONE: begin
            cmd.emit = stat.rsp_free;
         end
         default: cmd = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= caldc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// File: src/calendar_date_counter_unit.sv
// Sequence: a load passes through the step state without stepping and then the leap state;
// next and previous day take one step, plus the leap state when a year boundary is crossed;
// an add of N days takes N steps, plus the leap state after each year boundary crossed.
// Throughput: one request at a time; the stepping loop moves one day per cycle, pausing for the
// leap state, which recomputes the leap flag from the year after each year change.
// Reset: date returns to 1 January 2000 with the leap flag set; no response pending.
module calendar_date_counter_unit #(
   parameter int unsigned MAX_YEAR = 9999
) (
   input  logic       clock,
   input  logic       reset,
   caldc_req_if.sink  req_bus,
   caldc_rsp_if.source rsp_bus
);

   caldc_pkg::cmd_type  cmd;
   caldc_pkg::stat_type stat;

   caldc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   caldc_dpath #(
      .MAX_YEAR (MAX_YEAR)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_op           (req_bus.op),
      .req_day_count    (req_bus.day_count),
      .req_load_day     (req_bus.load_day),
      .req_load_month   (req_bus.load_month),
      .req_load_year    (req_bus.load_year),
      .rsp_ready        (rsp_bus.ready),
      .rsp_valid        (rsp_bus.valid),
      .rsp_out_day      (rsp_bus.out_day),
      .rsp_out_month    (rsp_bus.out_month),
      .rsp_out_year     (rsp_bus.out_year),
      .rsp_date_invalid (rsp_bus.date_invalid),
      .rsp_range_error  (rsp_bus.range_error)
   );

   a_busy_after_request: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("request taken while a previous one is in progress");

   a_year_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_bus.valid |-> (rsp_bus.out_year >= caldc_pkg::YEAR_W'(1) &&
                         rsp_bus.out_year <= caldc_pkg::YEAR_W'(MAX_YEAR)))
      else $error("response year outside the supported range");

   a_single_command: assert property (@(posedge clock) disable iff (reset)
      $onehot0({cmd.load, cmd.step, cmd.leap, cmd.emit}))
      else $error("controller issued more than one datapath command");

   a_emit_only_when_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> stat.rsp_free)
      else $error("response register overwritten before it was taken");

endmodule
